// File: src/cqrb_pkg.sv
package cqrb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int SIZE_W    = 7;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int ST_W      = 2;
    localparam int APB_DW    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIST = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_QUEUE_SIZE = '0;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic enq;
        logic deq;
        logic list;
        logic walk_emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic out_busy;
        logic walk_end;
    } stat_t;

endpackage

// File: src/cqrb_cfg.sv
module cqrb_cfg
    import cqrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic [SIZE_W-1:0] ring_len
);

    logic [SIZE_W-1:0]    queue_size_reg;
    logic [SIZE_W-1:0]    queue_size_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        queue_size_next = queue_size_reg;
        prdata          = '0;
        unique case (reg_idx)
            REG_QUEUE_SIZE:
            begin
                if (wr_en)
                begin
                    queue_size_next = pwdata[SIZE_W-1:0];
                end
                prdata = {{(APB_DW-SIZE_W){1'b0}}, queue_size_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_size_reg <= SIZE_W'(DEPTH);
        end
        else
        begin
            queue_size_reg <= queue_size_next;
        end
    end

    // zero acts as one, anything above the array acts as the full array
    always_comb
    begin
        if (queue_size_reg == '0)
        begin
            ring_len = SIZE_W'(1);
        end
        else if (queue_size_reg > SIZE_W'(DEPTH))
        begin
            ring_len = SIZE_W'(DEPTH);
        end
        else
        begin
            ring_len = queue_size_reg;
        end
    end

endmodule

// File: src/cqrb_ctrl.sv
module cqrb_ctrl
    import cqrb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [REQ_W-1:0] req_type,
    input  stat_t            stat,
    output logic             in_stall,
    output cmd_t             cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !stat.empty && (req_type == REQ_DEQ || req_type == REQ_LIST))
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (!stat.out_busy && stat.walk_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = stat.out_busy;
                cmd.enq  = in_valid && !stat.out_busy && (req_type == REQ_ENQ);
                cmd.deq  = in_valid && !stat.out_busy && (req_type == REQ_DEQ);
                cmd.list = in_valid && !stat.out_busy && (req_type == REQ_LIST);
            end
            S_WALK:
            begin
                in_stall      = 1'b1;
                cmd.walk_emit = !stat.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/cqrb_dpath.sv
module cqrb_dpath
    import cqrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic [SIZE_W-1:0]        ring_len,
    input  logic                     out_stall,
    output stat_t                    stat,
    output logic                     out_valid,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] data,
    output logic                     last
);

    localparam int IDX_W = $clog2(DEPTH);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                   input logic [SIZE_W-1:0] len);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(idx) + SIZE_W'(1);
        return (nxt >= len) ? '0 : nxt[IDX_W-1:0];
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [IDX_W-1:0] walk_idx_reg, walk_idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             single_reg, single_next;

    logic                     out_valid_reg, out_valid_next;
    logic [ST_W-1:0]          out_status_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_last_reg;

    logic                     load;
    logic [ST_W-1:0]          ld_status;
    logic signed [DATA_W-1:0] ld_data;
    logic                     ld_last;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic [IDX_W-1:0] tail_adv;
    logic [IDX_W-1:0] head_adv;
    logic [IDX_W-1:0] walk_adv;
    logic             walk_end;

    assign tail_adv = ring_next(tail_reg, ring_len);
    assign head_adv = ring_next(head_reg, ring_len);
    assign walk_adv = ring_next(walk_idx_reg, ring_len);

    // a dequeue is a walk of one; a listing also stops after DEPTH words
    assign walk_end = single_reg || (walk_idx_reg == tail_reg) ||
                      (cnt_reg == IDX_W'(DEPTH - 1));

    assign stat.empty    = empty_reg;
    assign stat.out_busy = out_valid_reg && out_stall;
    assign stat.walk_end = walk_end;

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        walk_idx_next = walk_idx_reg;
        cnt_next      = cnt_reg;
        single_next   = single_reg;
        load          = 1'b0;
        ld_status     = ST_OK;
        ld_data       = '0;
        ld_last       = 1'b1;
        wr_en         = 1'b0;
        wr_addr       = tail_adv;
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        if (cmd.enq)
        begin
            load = 1'b1;
            if (empty_reg)
            begin
                head_next  = '0;
                tail_next  = '0;
                empty_next = 1'b0;
                wr_en      = 1'b1;
                wr_addr    = '0;
            end
            else if (tail_adv == head_reg)
            begin
                ld_status = ST_FULL;
            end
            else
            begin
                tail_next = tail_adv;
                wr_en     = 1'b1;
                wr_addr   = tail_adv;
            end
        end

        if (cmd.deq)
        begin
            if (empty_reg)
            begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
            end
            else
            begin
                rd_en       = 1'b1;
                rd_addr     = head_reg;
                single_next = 1'b1;
                if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = head_adv;
                end
            end
        end

        if (cmd.list)
        begin
            if (empty_reg)
            begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
            end
            else
            begin
                rd_en         = 1'b1;
                rd_addr       = head_reg;
                walk_idx_next = head_reg;
                cnt_next      = '0;
                single_next   = 1'b0;
            end
        end

        if (cmd.walk_emit)
        begin
            load    = 1'b1;
            ld_data = rdata_reg;
            ld_last = walk_end;
            if (!walk_end)
            begin
                // fetch the next word so it is ready when this one is taken
                rd_en         = 1'b1;
                rd_addr       = walk_adv;
                walk_idx_next = walk_adv;
                cnt_next      = cnt_reg + IDX_W'(1);
            end
        end

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg <= walk_idx_next;
        cnt_reg      <= cnt_next;
        single_reg   <= single_next;
        if (load)
        begin
            out_status_reg <= ld_status;
            out_data_reg   <= ld_data;
            out_last_reg   <= ld_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

endmodule

// File: src/circular_queue_ring_buffer_unit.sv
// Ring-buffer queue of signed 32-bit words. Requests: enqueue (one word back, status ok or
// full), dequeue (oldest word, or status empty), list (every stored word oldest first, last
// set on the final one; an empty queue gives one empty word). The ring size is the
// queue_size register at byte address 0; 0 acts as 1 and values above DEPTH act as DEPTH.
// An enqueue or a request on an empty queue loads its word into the result register; a
// dequeue or a listing reads each word through the registered read port of the slot memory,
// and a listing streams one word per cycle while the output is not stalled. A stall on the
// output holds the result register and, while a word waits there, the input. Slots are not
// cleared at reset; the queue comes up empty and is usable in the first cycle after reset.
module circular_queue_ring_buffer_unit
    import cqrb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [REQ_W-1:0]         req_type,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [ST_W-1:0]          status,
    output logic signed [DATA_W-1:0] data,
    output logic                     last,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    cmd_t              cmd;
    stat_t             stat;
    logic [SIZE_W-1:0] ring_len;

    assign pready = 1'b1;

    cqrb_cfg #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .ring_len (ring_len)
    );

    cqrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    cqrb_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .ring_len  (ring_len),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .status    (status),
        .data      (data),
        .last      (last)
    );

endmodule

// File: src/cqrb_checker.sv
module cqrb_checker
    import cqrb_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [ST_W-1:0]          status,
    input logic signed [DATA_W-1:0] data,
    input logic                     last
);

    // a stalled word holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(data) &&
                                   $stable(last))
        else $error("output word changed while stalled");

    // no new request is taken in the middle of a listing
    a_no_accept_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input accepted while a listing is still running");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("full or empty word without last");

    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> data == '0)
        else $error("full or empty word with nonzero data");

endmodule

bind circular_queue_ring_buffer_unit cqrb_checker u_cqrb_checker (.*);
